FILE: rtl/trg_pkg.sv
// Shared types, codes and micro-programs of the trapezoidal ramp generator.
// Used by the controller, the datapath and the top level. No dependencies.
package trg_pkg;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_SU,
    OP_MUL_NUM,
    OP_GO_DIST,
    OP_WR_DIST,
    OP_GO_AT,
    OP_WR_AT,
    OP_GO_DT,
    OP_WR_DT,
    OP_MUL_VV,
    OP_GO_UL,
    OP_WR_UL,
    OP_GO_DL,
    OP_WR_DL,
    OP_REM1,
    OP_REM2,
    OP_GO_CR,
    OP_WR_CR,
    OP_SQ,
    OP_PLO,
    OP_PHI,
    OP_VI_HSQ,
    OP_OFF,
    OP_POS,
    OP_ADV
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic move_active;
    logic div_done;
  } dp_status_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_SPR  = 3'd0;
  localparam logic [2:0] CFG_USPS = 3'd1;
  localparam logic [2:0] CFG_DPR  = 3'd2;
  localparam logic [2:0] CFG_VMAX = 3'd3;
  localparam logic [2:0] CFG_AUP  = 3'd4;
  localparam logic [2:0] CFG_ADN  = 3'd5;

  // Segment codes (zero means no move running)
  localparam logic [1:0] SEG_IDLE   = 2'd0;
  localparam logic [1:0] SEG_ACCEL  = 2'd1;
  localparam logic [1:0] SEG_CRUISE = 2'd2;
  localparam logic [1:0] SEG_DECEL  = 2'd3;

  // Product terms saturate here before they are combined
  localparam logic [63:0] TERM_CAP = 64'h4000_0000_0000_0000;
  localparam logic [21:0] ELAPSED_MAX = 22'h3F_FFFF;

  localparam logic [4:0] SETUP_LAST = 5'd16;
  localparam logic [4:0] TICK_LAST  = 5'd5;

  // Start sequence
  function automatic op_e setup_op(input logic [4:0] step);
    op_e op;
    case (step)
      5'd0:    op = OP_MUL_SU;
      5'd1:    op = OP_MUL_NUM;
      5'd2:    op = OP_GO_DIST;
      5'd3:    op = OP_WR_DIST;
      5'd4:    op = OP_GO_AT;
      5'd5:    op = OP_WR_AT;
      5'd6:    op = OP_GO_DT;
      5'd7:    op = OP_WR_DT;
      5'd8:    op = OP_MUL_VV;
      5'd9:    op = OP_GO_UL;
      5'd10:   op = OP_WR_UL;
      5'd11:   op = OP_GO_DL;
      5'd12:   op = OP_WR_DL;
      5'd13:   op = OP_REM1;
      5'd14:   op = OP_REM2;
      5'd15:   op = OP_GO_CR;
      5'd16:   op = OP_WR_CR;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // Per-tick sample sequence
  function automatic op_e tick_op(input logic [4:0] step);
    op_e op;
    case (step)
      5'd0:    op = OP_SQ;
      5'd1:    op = OP_PLO;
      5'd2:    op = OP_PHI;
      5'd3:    op = OP_VI_HSQ;
      5'd4:    op = OP_OFF;
      5'd5:    op = OP_POS;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic is_div_go(input op_e op);
    return (op == OP_GO_DIST) || (op == OP_GO_AT) || (op == OP_GO_DT) ||
           (op == OP_GO_UL) || (op == OP_GO_DL) || (op == OP_GO_CR);
  endfunction

endpackage

FILE: rtl/trg_div.sv
// Restoring serial divider, one quotient bit per cycle, 64-bit quotient.
// A zero divisor yields an all-ones quotient. Depends on nothing.
module trg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic [63:0] quo_o,
  output logic        done_o
);

  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [33:0] trial;
  logic        fits;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[63]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? 33'(trial - {1'b0, den_q}) : trial[32:0];
    quo_d = {quo_q[62:0], fits};
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

FILE: rtl/trg_datapath.sv
// Datapath: config registers, move state, one shared 32x32 multiplier and
// the serial divider. Depends on trg_pkg and trg_div.
module trg_datapath #(
  parameter int COUNT_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trg_pkg::ctrl_cmd_t  cmd_i,
  output trg_pkg::dp_status_t status_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [23:0]         target_angle_i,
  input  logic signed [31:0]  start_position_i,
  output logic signed [47:0]  position_o,
  output logic [21:0]         tick_index_o,
  output logic [1:0]          segment_o,
  output logic                last_o
);
  import trg_pkg::*;

  localparam logic [63:0] CNT_MAX = 64'((65'd1 << COUNT_BITS) - 65'd1);

  // Configuration
  logic [15:0] spr_q, dpr_q;
  logic [8:0]  usps_q;
  logic [31:0] vmax_q, aup_q, adn_q;

  // Move state
  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] at_q, dt_q, cr_q;
  logic signed [47:0]    base_q, base_d;
  logic [21:0]           elapsed_q;
  logic                  last_d;

  // Working registers
  logic [23:0]        angle_q;
  logic signed [31:0] start_q;
  logic [24:0]        su_q;
  logic [48:0]        num_q;
  logic [31:0]        dist_q;
  logic [63:0]        vv_q, ul_q, dl_q, rem_q, sq_q, plo_q, phi_q, hsq_q, vi_q;
  logic signed [63:0] off_q;
  logic signed [47:0] pos_q;

  // Output register
  logic signed [47:0] out_pos_q;
  logic [21:0]        out_tick_q;
  logic [1:0]         out_seg_q;
  logic               out_last_q;

  logic [31:0] mul_a, mul_b, a_sel;
  logic [63:0] mul_p;
  logic [63:0] div_num, div_quo;
  logic [32:0] div_den;
  logic        div_done;
  logic [COUNT_BITS-1:0] quo_cnt, end_cnt;
  logic [95:0] sq_prod;
  logic [63:0] vi_sat, hsq_d;
  logic signed [63:0] pos_wide, off_d;
  logic signed [47:0] pos_sat;
  logic [63:0] rem0;

  assign a_sel = (phase_q == SEG_DECEL) ? adn_q : aup_q;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_SU:  begin mul_a = 32'(spr_q);  mul_b = 32'(usps_q);       end
      OP_MUL_NUM: begin mul_a = 32'(su_q);   mul_b = 32'(angle_q);      end
      OP_MUL_VV:  begin mul_a = vmax_q;      mul_b = vmax_q;            end
      OP_SQ:      begin mul_a = 32'(cnt_q);  mul_b = 32'(cnt_q);        end
      OP_PLO:     begin mul_a = a_sel;       mul_b = sq_q[31:0];        end
      OP_PHI:     begin mul_a = a_sel;       mul_b = sq_q[63:32];       end
      OP_VI_HSQ:  begin mul_a = vmax_q;      mul_b = 32'(cnt_q);        end
      default:    begin mul_a = '0;          mul_b = '0;                end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Divider operand selection
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd_i.op)
      OP_GO_DIST: begin div_num = 64'(num_q);  div_den = 33'({dpr_q, 8'h00}); end
      OP_GO_AT:   begin div_num = 64'(vmax_q); div_den = 33'(aup_q);          end
      OP_GO_DT:   begin div_num = 64'(vmax_q); div_den = 33'(adn_q);          end
      OP_GO_UL:   begin div_num = vv_q;        div_den = {aup_q, 1'b0};       end
      OP_GO_DL:   begin div_num = vv_q;        div_den = {adn_q, 1'b0};       end
      OP_GO_CR:   begin div_num = rem_q;       div_den = 33'(vmax_q);         end
      default:    begin div_num = '0;          div_den = '0;                  end
    endcase
  end

  trg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (is_div_go(cmd_i.op)),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // Saturated tick count from the quotient
  assign quo_cnt = (div_quo > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : div_quo[COUNT_BITS-1:0];

  // Half of a*i^2, capped before halving
  always_comb begin
    sq_prod = 96'(plo_q) + {phi_q, 32'h0};
    hsq_d   = (sq_prod > 96'(TERM_CAP)) ? (TERM_CAP >> 1) : sq_prod[64:1];
  end

  // Offset within the segment and saturated position
  always_comb begin
    vi_sat = (vi_q > TERM_CAP) ? TERM_CAP : vi_q;
    case (phase_q)
      SEG_ACCEL:  off_d = $signed(hsq_q);
      SEG_CRUISE: off_d = $signed(vi_sat);
      default:    off_d = $signed(vi_sat) - $signed(hsq_q);
    endcase
    pos_wide = 64'(base_q) + off_q;
    if (pos_wide > 64'sh0000_7FFF_FFFF_FFFF)       pos_sat = 48'sh7FFF_FFFF_FFFF;
    else if (pos_wide < -64'sh0000_8000_0000_0000) pos_sat = -48'sh8000_0000_0000;
    else                                           pos_sat = pos_wide[47:0];
  end

  // Segment advance after a sample
  always_comb begin
    case (phase_q)
      SEG_ACCEL:  end_cnt = at_q;
      SEG_CRUISE: end_cnt = cr_q;
      default:    end_cnt = dt_q;
    endcase
    phase_d = phase_q;
    base_d  = base_q;
    cnt_d   = cnt_q + 1'b1;
    last_d  = 1'b0;
    if (cnt_q >= end_cnt) begin
      base_d = pos_q;
      cnt_d  = COUNT_BITS'(1);
      if (phase_q == SEG_ACCEL && cr_q != '0) begin
        phase_d = SEG_CRUISE;
      end else if (phase_q != SEG_DECEL && dt_q != '0) begin
        phase_d = SEG_DECEL;
      end else begin
        phase_d = SEG_IDLE;
        last_d  = 1'b1;
      end
    end
  end

  // Configuration and move state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q     <= 16'd200;
      usps_q    <= 9'd16;
      dpr_q     <= 16'd360;
      vmax_q    <= 32'd65536;
      aup_q     <= 32'd6554;
      adn_q     <= 32'd6554;
      phase_q   <= SEG_IDLE;
      cnt_q     <= '0;
      at_q      <= '0;
      dt_q      <= '0;
      cr_q      <= '0;
      base_q    <= '0;
      dist_q    <= '0;
      elapsed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SPR:  spr_q  <= cfg_data_i[15:0];
          CFG_USPS: usps_q <= cfg_data_i[8:0];
          CFG_DPR:  dpr_q  <= cfg_data_i[15:0];
          CFG_VMAX: vmax_q <= cfg_data_i;
          CFG_AUP:  aup_q  <= cfg_data_i;
          CFG_ADN:  adn_q  <= cfg_data_i;
          default:  ;
        endcase
      end
      case (cmd_i.op)
        OP_WR_DIST: dist_q <= (div_quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_quo[31:0];
        OP_WR_AT:   at_q   <= quo_cnt;
        OP_WR_DT:   dt_q   <= quo_cnt;
        OP_WR_CR: begin
          cr_q      <= quo_cnt;
          base_q    <= {start_q, 16'h0000};
          phase_q   <= SEG_ACCEL;
          cnt_q     <= '0;
          elapsed_q <= '0;
        end
        OP_ADV: begin
          phase_q <= phase_d;
          base_q  <= base_d;
          cnt_q   <= cnt_d;
          if (elapsed_q != ELAPSED_MAX) elapsed_q <= elapsed_q + 22'd1;
        end
        default: ;
      endcase
    end
  end

  // Working and output registers
  assign rem0 = {16'h0000, dist_q, 16'h0000};
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        angle_q <= target_angle_i;
        start_q <= start_position_i;
      end
      OP_MUL_SU:  su_q  <= mul_p[24:0];
      OP_MUL_NUM: num_q <= mul_p[48:0];
      OP_MUL_VV:  vv_q  <= mul_p;
      OP_WR_UL:   ul_q  <= div_quo;
      OP_WR_DL:   dl_q  <= div_quo;
      OP_REM1:    rem_q <= (rem0 > ul_q) ? rem0 - ul_q : '0;
      OP_REM2:    rem_q <= (rem_q > dl_q) ? rem_q - dl_q : '0;
      OP_SQ:      sq_q  <= mul_p;
      OP_PLO:     plo_q <= mul_p;
      OP_PHI:     phi_q <= mul_p;
      OP_VI_HSQ: begin
        vi_q  <= mul_p;
        hsq_q <= hsq_d;
      end
      OP_OFF:     off_q <= off_d;
      OP_POS:     pos_q <= pos_sat;
      OP_ADV: begin
        out_pos_q  <= pos_q;
        out_tick_q <= elapsed_q;
        out_seg_q  <= phase_q;
        out_last_q <= last_d;
      end
      default: ;
    endcase
  end

  assign status_o.move_active = (phase_q != SEG_IDLE);
  assign status_o.div_done    = div_done;

  assign position_o   = out_pos_q;
  assign tick_index_o = out_tick_q;
  assign segment_o    = out_seg_q;
  assign last_o       = out_last_q;

endmodule

FILE: rtl/trg_ctrl.sv
// Controller: sequences the start set-up and the per-tick sample through
// the datapath, and owns both handshakes. Depends on trg_pkg.
module trg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  trg_pkg::dp_status_t status_i,
  output trg_pkg::ctrl_cmd_t  cmd_o
);
  import trg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SETUP    = 5'b00010,
    S_DIV_WAIT = 5'b00100,
    S_TICK     = 5'b01000,
    S_EMIT     = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  op_e        op;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Next state and issued operation
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    op          = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          step_d = '0;
          if (cmd_i) begin
            op      = OP_LOAD;
            state_d = S_SETUP;
          end else if (status_i.move_active) begin
            state_d = S_TICK;
          end
        end
      end
      S_SETUP: begin
        op     = setup_op(step_q);
        step_d = step_q + 5'd1;
        if (is_div_go(op)) state_d = S_DIV_WAIT;
        else if (step_q == SETUP_LAST) state_d = S_IDLE;
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) begin
          op     = setup_op(step_q);
          step_d = step_q + 5'd1;
          state_d = (step_q == SETUP_LAST) ? S_IDLE : S_SETUP;
        end
      end
      S_TICK: begin
        op     = tick_op(step_q);
        step_d = step_q + 5'd1;
        if (step_q == TICK_LAST) state_d = S_EMIT;
      end
      S_EMIT: begin
        // output register free or being emptied
        if (!out_valid_q || out_ready_i) begin
          op          = OP_ADV;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;

endmodule

FILE: rtl/trapezoidal_ramp_generator_unit.sv
// Top level of the trapezoidal ramp generator: controller plus datapath.
// Depends on trg_pkg, trg_ctrl, trg_datapath and trg_div.
//
// Usage: a request on the input channel with cmd_i = 1 starts a move from
// target_angle_i and start_position_i; it gives no result. A request with
// cmd_i = 0 is one time tick and, while a move runs, gives one position
// sample on the output channel; the final sample of a move has last_o set.
// Ticks with no move running are consumed silently.
// Start holds in_ready_o low through the set-up: six divisions on the serial
// divider (launch, one step per quotient bit, write-back) plus five
// multiply and subtract steps. A tick runs six steps, four of them on the
// shared 32x32 multiplier, then loads its sample into the output register;
// the load waits while that register is still full.
// One request is in flight at a time; in_ready_o is high only between them.
// A finished sample sits in the output register; if the receiver stalls,
// the next request is still taken and computed, and its sample waits until
// the register frees up.
// Configuration writes are always taken and must only arrive while idle.
// Reset restores the default register values and stops any move.
module trapezoidal_ramp_generator_unit #(
  parameter int COUNT_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [23:0]        target_angle_i,
  input  logic signed [31:0] start_position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] position_o,
  output logic [21:0]        tick_index_o,
  output logic [1:0]         segment_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import trg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  trg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  trg_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .target_angle_i   (target_angle_i),
    .start_position_i (start_position_i),
    .position_o       (position_o),
    .tick_index_o     (tick_index_o),
    .segment_o        (segment_o),
    .last_o           (last_o)
  );

  // A division only completes during start set-up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> !in_ready_o)
    else $error("divider finished outside set-up");

  // A freshly loaded final sample ends the move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && last_o) |-> !status.move_active)
    else $error("move still running after last sample");

  // Every sample belongs to a real segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (segment_o != SEG_IDLE))
    else $error("sample with no segment");

endmodule

FILE: bench/trapezoidal_ramp_generator_unit_tb.sv
// Self-checking bench for trapezoidal_ramp_generator_unit: directed table, then random moves.
// Holds its own ramp predictor and drives the valid/ready channels. Depends on trg_pkg.
module trapezoidal_ramp_generator_unit_tb;
  import trg_pkg::*;

  localparam int          CNT_BITS   = 20;
  localparam logic [63:0] CNT_MAX    = (64'd1 << CNT_BITS) - 1;
  localparam longint      POS_HI     = (64'sd1 <<< 47) - 1;
  localparam longint      POS_LO     = -(64'sd1 <<< 47);
  localparam int          WD_LIMIT   = 20000;
  localparam int          SETTLE     = 600;
  localparam int          RAND_ITEMS = 240;

  typedef struct packed {
    logic signed [47:0] pos;
    logic [21:0]        tick;
    logic [1:0]         seg;
    logic               last;
  } sample_t;

  typedef struct {
    logic        cmd;
    logic [23:0] angle;
    logic [31:0] start;
    int          reps;
    bit          typed;
    logic [47:0] pos;
    logic [1:0]  seg;
  } row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, cmd = 1'b0;
  logic [23:0] target_angle = '0;
  logic signed [31:0] start_position = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = CFG_SPR;
  logic [31:0] cfg_data = '0;
  logic in_ready, out_valid, last, cfg_ready;
  logic signed [47:0] position;
  logic [21:0] tick_index;
  logic [1:0] segment;

  // Predictor copy of the registers and the move state
  logic [63:0] spr, usps, dpr, vmax, aup, adn;
  logic [1:0]  mv_phase;
  logic [63:0] seg_cnt, acc_ticks, cru_ticks, dec_ticks, mv_dist, elapsed;
  longint      seg_base;

  sample_t expected_samples[$];
  int errors = 0, samples_seen = 0, starts_sent = 0, ticks_sent = 0, wd_count = 0;
  int burst_left = 0, gap_max = 4, stall_pct = 30;

  trapezoidal_ramp_generator_unit dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .target_angle_i(target_angle), .start_position_i(start_position),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .position_o(position), .tick_index_o(tick_index), .segment_o(segment), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ramp arithmetic
  function automatic logic [63:0] qdiv(input logic [63:0] n, input logic [63:0] d);
    return (d != 0) ? n / d : '1;
  endfunction

  function automatic logic [63:0] capped_mul(input logic [63:0] a, input logic [63:0] b);
    if (a != 0 && b > TERM_CAP / a) return TERM_CAP;
    return a * b;
  endfunction

  function automatic logic [63:0] half_sq(input logic [63:0] a, input logic [63:0] i);
    return capped_mul(a, i * i) >> 1;
  endfunction

  function automatic logic [63:0] clamp_count(input logic [63:0] x);
    return (x > CNT_MAX) ? CNT_MAX : x;
  endfunction

  task automatic reset_ramp_model();
    spr = 200; usps = 16; dpr = 360; vmax = 65536; aup = 6554; adn = 6554;
    mv_phase = SEG_IDLE;
    seg_cnt = 0; acc_ticks = 0; cru_ticks = 0; dec_ticks = 0;
    seg_base = 0; mv_dist = 0; elapsed = 0;
  endtask

  // Advance the ramp state for one accepted request; has is set when a sample follows
  task automatic predict_ramp(input logic c, input logic [23:0] a, input logic [31:0] p,
                              output bit has, output sample_t s);
    logic [63:0] up_len, down_len, rem, i, seg_end;
    longint off, pos;
    has = 0;
    s = '0;
    if (c) begin
      mv_dist = qdiv(spr * usps * {40'd0, a}, 256 * dpr);
      if (mv_dist > 64'hFFFF_FFFF) mv_dist = 64'hFFFF_FFFF;
      acc_ticks = clamp_count(qdiv(vmax, aup));
      dec_ticks = clamp_count(qdiv(vmax, adn));
      up_len = qdiv(vmax * vmax, 2 * aup);
      down_len = qdiv(vmax * vmax, 2 * adn);
      rem = mv_dist << 16;
      rem = (rem > up_len) ? rem - up_len : 0;
      rem = (rem > down_len) ? rem - down_len : 0;
      cru_ticks = clamp_count(qdiv(rem, vmax));
      seg_base = longint'(signed'(p)) * 65536;
      mv_phase = SEG_ACCEL;
      seg_cnt = 0;
      elapsed = 0;
    end else if (mv_phase != SEG_IDLE) begin
      has = 1;
      i = seg_cnt;
      case (mv_phase)
        SEG_ACCEL: begin
          off = longint'(half_sq(aup, i));
          seg_end = acc_ticks;
        end
        SEG_CRUISE: begin
          off = longint'(capped_mul(vmax, i));
          seg_end = cru_ticks;
        end
        default: begin
          off = longint'(capped_mul(vmax, i)) - longint'(half_sq(adn, i));
          seg_end = dec_ticks;
        end
      endcase
      pos = seg_base + off;
      if (pos > POS_HI) pos = POS_HI;
      if (pos < POS_LO) pos = POS_LO;
      s.pos = pos[47:0];
      s.tick = elapsed[21:0];
      s.seg = mv_phase;
      if (i >= seg_end) begin
        seg_base = pos;
        seg_cnt = 1;
        if (mv_phase == SEG_ACCEL && cru_ticks > 0) mv_phase = SEG_CRUISE;
        else if (mv_phase != SEG_DECEL && dec_ticks > 0) mv_phase = SEG_DECEL;
        else begin
          mv_phase = SEG_IDLE;
          s.last = 1'b1;
        end
      end else begin
        seg_cnt = i + 1;
      end
      if (elapsed < ELAPSED_MAX) elapsed++;
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h (sample %0d)", what, got, want, samples_seen);
    errors++;
  endtask

  // Send one request in bursts; predict at acceptance. typed overrides the sample
  task automatic send_request(input logic c, input logic [23:0] a, input logic [31:0] p,
                              input bit typed, input sample_t typed_s);
    bit has;
    sample_t s;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    target_angle <= a;
    start_position <= p;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_ramp(c, a, p, has, s);
    if (c) starts_sent++;
    else ticks_sent++;
    if (has) expected_samples = {expected_samples, (typed ? typed_s : s)};
  endtask

  // Start an empty move and tick it out so the block is idle
  task automatic finish_move();
    send_request(1'b1, 24'd0, $urandom, 1'b0, '0);
    while (mv_phase != SEG_IDLE) send_request(1'b0, 24'($urandom), $urandom, 1'b0, '0);
    in_valid <= 1'b0;
    wait (expected_samples.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] vals[6]);
    for (int r = 0; r < 6; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= r[2:0];
      cfg_data <= vals[r];
      do @(negedge clk); while (!cfg_ready);
      @(posedge clk);
      case (r[2:0])
        CFG_SPR:  spr = {48'd0, vals[r][15:0]};
        CFG_USPS: usps = {55'd0, vals[r][8:0]};
        CFG_DPR:  dpr = {48'd0, vals[r][15:0]};
        CFG_VMAX: vmax = {32'd0, vals[r]};
        CFG_AUP:  aup = {32'd0, vals[r]};
        default:  adn = {32'd0, vals[r]};
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls and output checking
  always @(posedge clk) begin
    sample_t e;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_ni && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report("unexpected sample", {16'h0000, position}, 64'd0);
      end else begin
        e = expected_samples.pop_front();
        if (position !== e.pos) report("position", position, e.pos);
        if (tick_index !== e.tick) report("tick_index", tick_index, e.tick);
        if (segment !== e.seg) report("segment", segment, e.seg);
        if (last !== e.last) report("last", last, e.last);
      end
      samples_seen++;
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      wd_count <= 0;
    else if (wd_count >= WD_LIMIT) begin
      $display("[trapezoidal_ramp_generator_unit] ERROR");
      $finish;
    end else
      wd_count <= wd_count + 1;
  end

  initial begin
    row_t table_rows[$];
    logic [31:0] cfg_set[6];
    sample_t ts;
    logic [23:0] ang;
    int sent;

    reset_ramp_model();
    // cmd, angle, start, repeats, typed, position, segment
    table_rows = '{
      '{1'b0, 24'd0,       32'd0,         1, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b1, 24'd0,       32'd0,         1, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b0, 24'd0,       32'd0,         1, 1'b1, 48'd0,              SEG_ACCEL},
      '{1'b1, 24'd0,       32'h8000_0000, 1, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b0, 24'd0,       32'd0,         1, 1'b1, 48'h8000_0000_0000, SEG_ACCEL},
      '{1'b1, 24'd0,       32'h7FFF_FFFF, 1, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b0, 24'd0,       32'd0,         1, 1'b1, 48'h7FFF_FFFF_0000, SEG_ACCEL},
      '{1'b0, 24'd0,       32'd0,        18, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b0, 24'hFF_FFFF, 32'hFFFF_FFFF, 2, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b1, 24'hFF_FFFF, 32'h7FFF_FFFF, 1, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b0, 24'd0,       32'd0,        40, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b1, 24'd100,     32'h8000_0000, 1, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b0, 24'd0,       32'd0,        30, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b1, 24'd2560,    32'hA5A5_5A5A, 1, 1'b0, 48'd0,              SEG_IDLE},
      '{1'b0, 24'd0,       32'd0,        20, 1'b0, 48'd0,              SEG_IDLE}
    };

    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed table under the reset settings
    foreach (table_rows[k]) begin
      ts = '0;
      ts.pos = table_rows[k].pos;
      ts.seg = table_rows[k].seg;
      repeat (table_rows[k].reps)
        send_request(table_rows[k].cmd, table_rows[k].angle, table_rows[k].start,
                     table_rows[k].typed, ts);
    end

    // Random phases: reset values, both extremes, random, then back to reset values
    for (int ph = 0; ph < 6; ph++) begin
      finish_move();
      case (ph)
        0: cfg_set = '{32'd200, 32'd16, 32'd360, 32'd65536, 32'd6554, 32'd6554};
        1: cfg_set = '{32'hFFFF, 32'd256, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF};
        2: cfg_set = '{32'd1, 32'd1, 32'hFFFF, 32'd1, 32'd1, 32'd1};
        5: cfg_set = '{32'd200, 32'd16, 32'd360, 32'd65536, 32'd6554, 32'd6554};
        default: begin
          cfg_set[0] = $urandom_range(1, 400);
          cfg_set[1] = $urandom_range(1, 32);
          cfg_set[2] = $urandom_range(90, 65535);
          cfg_set[3] = $urandom_range(1 << 10, 1 << 22);
          cfg_set[4] = cfg_set[3] / $urandom_range(1, 40) + 1;
          cfg_set[5] = cfg_set[3] / $urandom_range(1, 40) + 1;
        end
      endcase
      write_config(cfg_set);
      gap_max = (ph == 3) ? 0 : $urandom_range(1, 8);
      stall_pct = (ph == 4) ? 0 : $urandom_range(10, 70);
      sent = 0;
      while (sent < RAND_ITEMS) begin
        if (ph == 2 && sent == RAND_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait (expected_samples.size() == 0);
          @(posedge clk);
        end
        if (mv_phase == SEG_IDLE || $urandom_range(0, 24) == 0) begin
          ang = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
          send_request(1'b1, ang, $urandom, 1'b0, '0);
          sent++;
        end else begin
          send_request(1'b0, 24'($urandom), $urandom, 1'b0, '0);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    wait (expected_samples.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d starts and %0d ticks over 7 register settings", starts_sent,
             ticks_sent);
    $display("%0d position samples checked, %0d mismatches", samples_seen, errors);
    if (errors == 0)
      $display("[trapezoidal_ramp_generator_unit] OK");
    else
      $display("[trapezoidal_ramp_generator_unit] ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/trg_pkg.sv
rtl/trg_div.sv
rtl/trg_datapath.sv
rtl/trg_ctrl.sv
rtl/trapezoidal_ramp_generator_unit.sv
bench/trapezoidal_ramp_generator_unit_tb.sv
